// ----- hdl/abiog_pkg.sv -----
// shared types and constants for the arcade board interrupt and i/o glue
// used by the top level and by its port checker; no dependencies

package abiog_pkg;

  // command codes on the input channel
  localparam logic [2:0] CMD_READ        = 3'd0;
  localparam logic [2:0] CMD_WRITE       = 3'd1;
  localparam logic [2:0] CMD_FRAME_START = 3'd2;
  localparam logic [2:0] CMD_VBLANK      = 3'd3;
  localparam logic [2:0] CMD_SOUND_LINE  = 3'd4;

  // sound strobe codes
  localparam logic [1:0] SS_NONE   = 2'd0;
  localparam logic [1:0] SS_SELECT = 2'd1;
  localparam logic [1:0] SS_WRITE  = 2'd2;

  // video strobe codes
  localparam logic [2:0] VS_NONE   = 3'd0;
  localparam logic [2:0] VS_TILE0  = 3'd1;
  localparam logic [2:0] VS_TILE1  = 3'd2;
  localparam logic [2:0] VS_TILE2  = 3'd3;
  localparam logic [2:0] VS_XOFS   = 3'd4;
  localparam logic [2:0] VS_YOFS   = 3'd5;
  localparam logic [2:0] VS_SPRITE = 3'd6;

  // bus map
  localparam logic [23:0] ADDR_STATUS_A = 24'h1C0000;
  localparam logic [23:0] ADDR_STATUS_B = 24'h300000;
  localparam logic [23:0] ADDR_SPRITE_A = 24'h1C0008;
  localparam logic [23:0] ADDR_SPRITE_B = 24'h300008;
  localparam logic [23:0] ADDR_TILE     = 24'h140000;
  localparam logic [23:0] ADDR_SOUND    = 24'h240000;
  localparam logic [23:0] ADDR_PORT0    = 24'h280000;
  localparam logic [23:0] ADDR_PORT1    = 24'h280002;
  localparam logic [23:0] ADDR_CONTROL  = 24'h28000A;

  // port merge masks
  localparam logic [15:0] PORT0_MASK = 16'h5FFF;
  localparam logic [15:0] PORT1_MASK = 16'hEFFF;

  // status window offsets
  localparam logic [2:0] OFS_XOFS = 3'd0;
  localparam logic [2:0] OFS_YOFS = 3'd2;

endpackage

// ----- hdl/arcade_board_irq_and_io_glue.sv -----
// board glue for a 68000 bus: interrupt flags, status windows, input ports,
// sound and video strobes, hopper and eeprom latches
// depends on abiog_pkg

// an accepted word's result is loaded into the output register in the next cycle
// throughput: one word per cycle; in_ready stays high while the output register
//   is empty or being drained, so bursts run back to back
// reset (rst, synchronous, active high): interrupt flags released (high), vblank
//   and hopper and eeprom latches cleared, service switch off (1), output empty

module arcade_board_irq_and_io_glue (
  input  logic        clk,
  input  logic        rst,
  // configuration: service dip bit
  input  logic        cfg_write_enable,
  input  logic        cfg_write_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [23:0] address,
  input  logic        is_word,
  input  logic [15:0] write_data,
  input  logic        sound_line,
  input  logic [15:0] port_zero,
  input  logic [15:0] port_one,
  input  logic        eeprom_bit,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] read_data,
  output logic        irq_pending,
  output logic        eeprom_clock,
  output logic        eeprom_select,
  output logic        eeprom_data_in,
  output logic        hopper_drive,
  output logic [1:0]  sound_strobe,
  output logic [7:0]  sound_byte,
  output logic [2:0]  video_strobe,
  output logic [15:0] video_value,
  output logic        sprite_swap
);

  // board state
  logic       service_switch;
  logic       video_flag_n, sound_flag_n, unknown_flag_n;
  logic       in_vblank, hopper_latch;
  logic [2:0] eeprom_lines; // bit 0 select, bit 1 clock, bit 2 data in

  logic       video_flag_n_next, sound_flag_n_next, unknown_flag_n_next;
  logic       in_vblank_next, hopper_latch_next;
  logic [2:0] eeprom_lines_next;

  // result word being built
  logic [15:0] rd;
  logic [1:0]  ss;
  logic [7:0]  sb;
  logic [2:0]  vs;
  logic        sw;

  logic        accept;
  logic        status_hit;
  logic [2:0]  ofs;
  logic [7:0]  ctl_byte;
  logic        ctl_load;

  // the output register frees itself in the same cycle it is drained
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  // both status windows are eight bytes and mirror each other
  assign status_hit = (address[23:3] == abiog_pkg::ADDR_STATUS_A[23:3]) ||
                      (address[23:3] == abiog_pkg::ADDR_STATUS_B[23:3]);
  assign ofs = address[2:0];

  always_comb begin
    video_flag_n_next   = video_flag_n;
    sound_flag_n_next   = sound_flag_n;
    unknown_flag_n_next = unknown_flag_n;
    in_vblank_next      = in_vblank;
    hopper_latch_next   = hopper_latch;
    eeprom_lines_next   = eeprom_lines;
    rd       = 16'h0000;
    ss       = abiog_pkg::SS_NONE;
    sb       = 8'h00;
    vs       = abiog_pkg::VS_NONE;
    sw       = 1'b0;
    ctl_byte = 8'h00;
    ctl_load = 1'b0;

    unique case (cmd)
      abiog_pkg::CMD_READ: begin
        if (status_hit) begin
          if (is_word && ofs[0]) begin
            // odd word read in the window: nothing matches
            rd = 16'h0000;
          end else if (ofs[2:1] == 2'b00) begin
            // vblank bit polarity differs between byte and word reads
            rd = {13'b0, ~(in_vblank ^ is_word), unknown_flag_n, video_flag_n};
          end else begin
            // offsets 4-5 ack video, 6-7 ack unknown; status shows the acked flags
            if (ofs[2] && !ofs[1]) video_flag_n_next = 1'b1;
            if (ofs[2] && ofs[1])  unknown_flag_n_next = 1'b1;
            rd = {14'b0, unknown_flag_n_next, video_flag_n_next};
          end
        end else if (is_word) begin
          if (address == abiog_pkg::ADDR_PORT0) begin
            rd = (port_zero & abiog_pkg::PORT0_MASK) |
                 {~hopper_latch, 1'b0, service_switch, 13'b0};
          end else if (address == abiog_pkg::ADDR_PORT1) begin
            rd = (port_one & abiog_pkg::PORT1_MASK) | {3'b0, eeprom_bit, 12'b0};
          end
        end else begin
          if (address == abiog_pkg::ADDR_PORT0) begin
            rd = {8'h00, ~hopper_latch, port_zero[14], service_switch, port_zero[12:8]};
          end else if (address == abiog_pkg::ADDR_PORT0 + 24'd1) begin
            rd = {8'h00, port_zero[7:0]};
          end else if (address == abiog_pkg::ADDR_PORT1) begin
            rd = {8'h00, port_one[15:13], eeprom_bit, port_one[11:8]};
          end else if (address == abiog_pkg::ADDR_PORT1 + 24'd1) begin
            rd = {8'h00, port_one[7:0]};
          end
        end
      end

      abiog_pkg::CMD_WRITE: begin
        if (is_word) begin
          // priority follows the bus map: tiles, scroll offsets, sprite bank, sound, control
          if (address == abiog_pkg::ADDR_TILE) begin
            vs = abiog_pkg::VS_TILE0;
          end else if (address == abiog_pkg::ADDR_TILE + 24'd2) begin
            vs = abiog_pkg::VS_TILE1;
          end else if (address == abiog_pkg::ADDR_TILE + 24'd4) begin
            vs = abiog_pkg::VS_TILE2;
          end else if (status_hit && ofs == abiog_pkg::OFS_XOFS) begin
            vs = abiog_pkg::VS_XOFS;
          end else if (status_hit && ofs == abiog_pkg::OFS_YOFS) begin
            vs = abiog_pkg::VS_YOFS;
          end else if (address == abiog_pkg::ADDR_SPRITE_A ||
                       address == abiog_pkg::ADDR_SPRITE_B) begin
            vs = abiog_pkg::VS_SPRITE;
            sw = 1'b1;
          end else if (address == abiog_pkg::ADDR_SOUND) begin
            ss = abiog_pkg::SS_SELECT;
            sb = write_data[7:0];
          end else if (address == abiog_pkg::ADDR_SOUND + 24'd2) begin
            ss = abiog_pkg::SS_WRITE;
            sb = write_data[7:0];
          end else if (address == abiog_pkg::ADDR_CONTROL) begin
            ctl_load = 1'b1;
            ctl_byte = write_data[15:8];
          end
        end else begin
          // byte writes never reach the video registers
          if (address == abiog_pkg::ADDR_SOUND + 24'd1) begin
            ss = abiog_pkg::SS_SELECT;
            sb = write_data[7:0];
          end else if (address == abiog_pkg::ADDR_SOUND + 24'd3) begin
            ss = abiog_pkg::SS_WRITE;
            sb = write_data[7:0];
          end else if (address == abiog_pkg::ADDR_CONTROL) begin
            ctl_load = 1'b1;
            ctl_byte = write_data[7:0];
          end
        end
      end

      abiog_pkg::CMD_FRAME_START: begin
        in_vblank_next = 1'b0;
      end

      abiog_pkg::CMD_VBLANK: begin
        in_vblank_next    = 1'b1;
        video_flag_n_next = 1'b0;
      end

      abiog_pkg::CMD_SOUND_LINE: begin
        sound_flag_n_next = ~sound_line;
      end

      default: begin
        // unused commands leave the state alone
      end
    endcase

    // control byte: bit 0 hopper, bits 6:4 eeprom lines
    if (ctl_load) begin
      hopper_latch_next = ctl_byte[0];
      eeprom_lines_next = ctl_byte[6:4];
    end
  end

  // state updates on each accepted word; the service switch on each configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      service_switch <= 1'b1;
      video_flag_n   <= 1'b1;
      sound_flag_n   <= 1'b1;
      unknown_flag_n <= 1'b1;
      in_vblank      <= 1'b0;
      hopper_latch   <= 1'b0;
      eeprom_lines   <= 3'b000;
    end else begin
      if (cfg_write_enable) service_switch <= cfg_write_data;
      if (accept) begin
        video_flag_n   <= video_flag_n_next;
        sound_flag_n   <= sound_flag_n_next;
        unknown_flag_n <= unknown_flag_n_next;
        in_vblank      <= in_vblank_next;
        hopper_latch   <= hopper_latch_next;
        eeprom_lines   <= eeprom_lines_next;
      end
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload, shows the state after the word's update
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data      <= rd;
      irq_pending    <= ~(video_flag_n_next & sound_flag_n_next & unknown_flag_n_next);
      eeprom_clock   <= eeprom_lines_next[1];
      eeprom_select  <= eeprom_lines_next[0];
      eeprom_data_in <= eeprom_lines_next[2];
      hopper_drive   <= hopper_latch_next;
      sound_strobe   <= ss;
      sound_byte     <= sb;
      video_strobe   <= vs;
      video_value    <= (vs != abiog_pkg::VS_NONE) ? write_data : 16'h0000;
      sprite_swap    <= sw;
    end
  end

endmodule

// ----- hdl/abiog_checker.sv -----
// port-level checks for the arcade board glue, bound to the top level
// depends on abiog_pkg and arcade_board_irq_and_io_glue

module abiog_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] read_data,
  input logic [1:0]  sound_strobe,
  input logic [7:0]  sound_byte,
  input logic [2:0]  video_strobe,
  input logic [15:0] video_value,
  input logic        sprite_swap
);

  // a stalled result word stays valid and keeps its read data and video value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(video_value))
    else $error("result word changed while stalled");

  // one write drives at most one strobe
  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    out_valid && sound_strobe != abiog_pkg::SS_NONE |-> video_strobe == abiog_pkg::VS_NONE)
    else $error("sound and video strobes together");

  // sprite swap pulses only with a sprite bank write
  a_swap_bank: assert property (@(posedge clk) disable iff (rst)
    out_valid && sprite_swap |-> video_strobe == abiog_pkg::VS_SPRITE)
    else $error("sprite swap without sprite bank strobe");

  // strobe data is zero without a strobe, and a strobed word reads nothing
  a_quiet_data: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((sound_strobe == abiog_pkg::SS_NONE) ? (sound_byte == 8'h00) :
                                              (read_data == 16'h0000)) &&
      ((video_strobe == abiog_pkg::VS_NONE) ? (video_value == 16'h0000) :
                                              (read_data == 16'h0000)))
    else $error("strobe data or read data inconsistent");

  // the output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind arcade_board_irq_and_io_glue abiog_checker u_abiog_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_data    (read_data),
  .sound_strobe (sound_strobe),
  .sound_byte   (sound_byte),
  .video_strobe (video_strobe),
  .video_value  (video_value),
  .sprite_swap  (sprite_swap)
);
